FILE: src/dsp_pkg.sv
// Package for the shortest path engine: widths, request and status codes
// and the payload structs. No dependencies.
`default_nettype none
package dsp_pkg;
    localparam int VBITS = 8;
    localparam int EBITS = 10;
    localparam int WBITS = 16;
    localparam int DBITS = 24;
    localparam int NV = 256;
    localparam int NE = 1024;
    localparam logic [DBITS-1:0] INF = {DBITS{1'b1}};

    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_AVOID = 3'd1;
    localparam logic [2:0] REQ_CLEAR = 3'd2;
    localparam logic [2:0] REQ_RUN   = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;

    // edge record: from, to, drive weight, walk weight, drivable, avoided
    localparam int EREC = 2*VBITS + 2*WBITS + 2;
    // vertex record: distance, seen, extracted, avoid, dvalid, dpred, wvalid, wpred
    localparam int VREC = DBITS + 3 + 2*(1+EBITS);

    typedef struct packed {
        logic [DBITS-1:0] vdist;
        logic             seen;
        logic             done;
        logic             avoid;
        logic             dok;
        logic [EBITS-1:0] dpe;
        logic             wok;
        logic [EBITS-1:0] wpe;
    } t_vrec;

    typedef struct packed {
        logic [VBITS-1:0] from;
        logic [VBITS-1:0] to;
        logic [WBITS-1:0] dw;
        logic [WBITS-1:0] ww;
        logic             drive;
        logic             excl;
    } t_erec;

    typedef struct packed {
        logic [1:0]       status;
        logic [DBITS-1:0] distance;
        logic             reachable;
        logic             dok;
        logic [EBITS-1:0] dpe;
        logic             wok;
        logic [EBITS-1:0] wpe;
        logic [VBITS-1:0] src;
    } t_res;
endpackage
`default_nettype wire

FILE: src/dsp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module dsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/dijkstra_shortest_path_engine_top.sv
// Shortest path engine (Dijkstra) over a loaded directed graph.
// Uses dsp_pkg and dsp_ram (edge memory and vertex memory).
//
// Requests arrive one per transfer on the s_axis side; each gives exactly one
// result transfer on the m_axis side. After reset the 256-entry vertex memory
// is swept, one entry a cycle, before the first request is taken. Edge loads
// and unknown requests are answered from the idle state, avoid marks read and
// then write the vertex, and queries read the vertex, then the edge for the
// predecessor source. Clear graph sweeps the vertex memory again. A search
// sweeps the vertex memory, then repeats: a scan of all 256 vertices for the
// lowest unextracted distance, a vertex read and write to mark it extracted,
// a scan of all loaded edges (an edge read, then a vertex read and write per
// edge) to relax successors, and a wait state to let the last write land. A
// drive search with a destination can stop early; the vertex memory port is
// the bottleneck. The edge memory is never cleared; only entries below the
// edge count are read. One result is held in an output register; a new
// request can be taken in the cycle that result leaves.
`default_nettype none
module dijkstra_shortest_path_engine_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: vertex_a[8] vertex_b[8] has_destination[1] drive_cost[16]
    // can_drive[1] walk_cost[16] edge_excluded[1] vertex_excluded[1] walk_mode[1]
    input  wire [55:0]  s_axis_tdata,
    // tuser: req_type[3]
    input  wire [2:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata from bit 0: distance[24] reachable[1] drive_pred_valid[1]
    // drive_pred_edge[10] walk_pred_valid[1] walk_pred_edge[10] pred_source[8]
    output logic [55:0] m_axis_tdata,
    // tuser: status[2]
    output logic [1:0]  m_axis_tuser
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_QV    = 4'd2;
    localparam logic [3:0] S_QE    = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_EXT   = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_EWT   = 4'd8;
    localparam logic [3:0] S_VWT   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_EXT2  = 4'd11;
    localparam logic [3:0] S_SWAIT = 4'd12;

    logic [3:0] r_st, n_st;
    logic [dsp_pkg::VBITS:0]   r_vc, n_vc;      // sweep / scan counter
    logic [dsp_pkg::EBITS:0]   r_ec, n_ec;      // edge scan counter
    logic [dsp_pkg::EBITS:0]   r_ecount, n_ecount;
    logic                      r_last_walk, n_last_walk;
    logic                      r_walk, n_walk, r_stop, n_stop;
    logic [dsp_pkg::VBITS-1:0] r_a, n_a, r_b, n_b, r_best, n_best;
    logic                      r_found, n_found;
    logic [dsp_pkg::DBITS-1:0] r_bdist, n_bdist;
    dsp_pkg::t_vrec            r_qv, n_qv;
    dsp_pkg::t_erec            r_e, n_e;
    logic                      r_ovalid, n_ovalid;
    dsp_pkg::t_res             r_res, n_res;
    // marks a clear sweep that came from a request rather than from reset
    logic                      r_res_pending;

    // memories
    logic                      v_we, e_we;
    logic [dsp_pkg::VBITS-1:0] v_wa, v_ra;
    logic [dsp_pkg::EBITS-1:0] e_wa, e_ra;
    dsp_pkg::t_vrec            v_wd, v_rd;
    dsp_pkg::t_erec            e_wd, e_rd;

    dsp_ram #(.WIDTH(dsp_pkg::VREC), .DEPTH(dsp_pkg::NV)) u_vmem (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    dsp_ram #(.WIDTH(dsp_pkg::EREC), .DEPTH(dsp_pkg::NE)) u_emem (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));

    wire [dsp_pkg::VBITS-1:0] in_a = s_axis_tdata[7:0];
    wire [dsp_pkg::VBITS-1:0] in_b = s_axis_tdata[15:8];
    wire in_fire = s_axis_tvalid && s_axis_tready;

    // take a new request while the held result is leaving
    assign s_axis_tready = (r_st == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {1'b0, r_res.src, r_res.wpe, r_res.wok, r_res.dpe, r_res.dok,
                            r_res.reachable, r_res.distance};

    logic [dsp_pkg::DBITS:0]   sum;
    logic [dsp_pkg::DBITS-1:0] sat;
    dsp_pkg::t_vrec            v_upd;

    always_comb begin
        n_st = r_st; n_vc = r_vc; n_ec = r_ec; n_ecount = r_ecount;
        n_last_walk = r_last_walk; n_walk = r_walk; n_stop = r_stop;
        n_a = r_a; n_b = r_b; n_best = r_best; n_found = r_found;
        n_bdist = r_bdist; n_qv = r_qv; n_e = r_e;
        n_ovalid = r_ovalid; n_res = r_res;
        v_we = 1'b0; v_wa = r_vc[dsp_pkg::VBITS-1:0]; v_wd = v_rd;
        v_ra = r_vc[dsp_pkg::VBITS-1:0];
        e_we = 1'b0; e_wa = r_ecount[dsp_pkg::EBITS-1:0]; e_wd = '0;
        e_ra = r_ec[dsp_pkg::EBITS-1:0];
        sum = '0; sat = '0; v_upd = v_rd;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (in_fire) begin
                    n_res = '0;
                    n_a = in_a; n_b = in_b;
                    n_walk = s_axis_tdata[52];
                    n_stop = s_axis_tdata[16];
                    n_vc = '0;
                    case (s_axis_tuser)
                        dsp_pkg::REQ_LOAD: begin
                            n_ovalid = 1'b1;
                            if (r_ecount[dsp_pkg::EBITS]) begin
                                n_res.status = dsp_pkg::ST_FULL;
                            end else begin
                                e_we = 1'b1;
                                e_wd = {in_a, in_b, s_axis_tdata[32:17],
                                        s_axis_tdata[49:34], s_axis_tdata[33],
                                        s_axis_tdata[50]};
                                n_ecount = r_ecount + 1'b1;
                            end
                        end
                        dsp_pkg::REQ_AVOID: begin
                            // read-modify-write of the avoid bit
                            v_ra = in_a;
                            n_st = S_VWT;
                        end
                        dsp_pkg::REQ_CLEAR: begin
                            n_ecount = '0;
                            n_last_walk = 1'b0;
                            n_st = S_CLR;
                        end
                        dsp_pkg::REQ_RUN: begin
                            n_last_walk = s_axis_tdata[52];
                            v_ra = '0;
                            n_st = S_INIT;
                        end
                        dsp_pkg::REQ_QUERY: begin
                            v_ra = in_a;
                            n_st = S_QV;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                    if (s_axis_tuser == dsp_pkg::REQ_AVOID) begin
                        n_e.excl = s_axis_tdata[51];
                    end
                end
            end
            S_VWT: begin
                v_wa = r_a; v_we = 1'b1;
                v_wd = v_rd; v_wd.avoid = r_e.excl;
                n_ovalid = 1'b1; n_st = S_IDLE;
            end
            S_CLR: begin
                v_we = 1'b1;
                v_wd = '0; v_wd.vdist = dsp_pkg::INF;
                n_vc = r_vc + 1'b1;
                if (r_vc[dsp_pkg::VBITS-1:0] == '1) begin
                    n_ovalid = 1'b1; n_st = S_IDLE;
                end
            end
            S_QV: begin
                n_qv = v_rd;
                e_ra = r_last_walk ? v_rd.wpe : v_rd.dpe;
                n_st = S_QE;
            end
            S_QE: begin
                n_res.distance  = r_qv.vdist;
                n_res.reachable = r_qv.vdist != dsp_pkg::INF;
                n_res.dok = r_qv.dok;
                n_res.dpe = r_qv.dok ? r_qv.dpe : '0;
                n_res.wok = r_qv.wok;
                n_res.wpe = r_qv.wok ? r_qv.wpe : '0;
                n_res.src = (r_last_walk ? r_qv.wok : r_qv.dok) ? e_rd.from : '0;
                n_ovalid = 1'b1; n_st = S_IDLE;
            end
            S_INIT: begin
                // v_rd holds entry r_vc; reset this mode's fields
                v_we = 1'b1;
                v_wd = v_rd;
                v_wd.vdist = (r_vc[dsp_pkg::VBITS-1:0] == r_a) ? '0 : dsp_pkg::INF;
                v_wd.seen = r_vc[dsp_pkg::VBITS-1:0] == r_a;
                v_wd.done = 1'b0;
                if (r_walk) begin
                    v_wd.wok = 1'b0; v_wd.wpe = '0;
                end else begin
                    v_wd.dok = 1'b0; v_wd.dpe = '0;
                end
                n_vc = r_vc + 1'b1;
                v_ra = n_vc[dsp_pkg::VBITS-1:0];
                if (r_vc[dsp_pkg::VBITS-1:0] == '1) begin
                    n_vc = '0; v_ra = '0; n_found = 1'b0; n_st = S_SCAN;
                end
            end
            S_SCAN: begin
                // v_rd holds entry r_vc; strict compare keeps lowest index
                if (v_rd.seen && !v_rd.done && (!r_found || v_rd.vdist < r_bdist)) begin
                    n_found = 1'b1;
                    n_best = r_vc[dsp_pkg::VBITS-1:0];
                    n_bdist = v_rd.vdist;
                end
                n_vc = r_vc + 1'b1;
                v_ra = n_vc[dsp_pkg::VBITS-1:0];
                if (r_vc[dsp_pkg::VBITS-1:0] == '1) begin
                    n_vc = '0;
                    v_ra = n_best;
                    n_st = n_found ? S_EXT : S_DONE;
                    if (n_found) v_ra = n_best;
                end
            end
            S_EXT: begin
                v_ra = r_best;
                n_st = S_EXT2;
            end
            S_EXT2: begin
                v_we = 1'b1; v_wa = r_best;
                v_wd = v_rd; v_wd.done = 1'b1;
                n_ec = '0; e_ra = '0;
                if (!r_walk && r_stop && r_best == r_b) begin
                    n_st = S_DONE;
                end else begin
                    // with no edges nothing else can ever be reached
                    n_st = (r_ecount == '0) ? S_DONE : S_ERD;
                    n_found = 1'b0;
                end
            end
            S_ERD: begin
                // e_rd holds edge r_ec
                n_e = e_rd;
                v_ra = e_rd.to;
                n_st = S_EWT;
            end
            S_EWT: begin
                // v_rd holds target vertex record
                sum = {1'b0, r_bdist} + {{(dsp_pkg::DBITS-dsp_pkg::WBITS+1){1'b0}},
                      (r_walk ? r_e.ww : r_e.dw)};
                sat = (sum >= {1'b0, dsp_pkg::INF}) ? dsp_pkg::INF
                                                    : sum[dsp_pkg::DBITS-1:0];
                v_upd = v_rd;
                v_upd.vdist = sat; v_upd.seen = 1'b1;
                if (r_walk) begin
                    v_upd.wok = 1'b1; v_upd.wpe = r_ec[dsp_pkg::EBITS-1:0];
                end else begin
                    v_upd.dok = 1'b1; v_upd.dpe = r_ec[dsp_pkg::EBITS-1:0];
                end
                v_wa = r_e.to; v_wd = v_upd;
                v_we = (r_e.from == r_best) && !r_e.excl && !v_rd.avoid
                       && (r_walk || r_e.drive) && (v_rd.vdist > sat);
                n_ec = r_ec + 1'b1;
                e_ra = n_ec[dsp_pkg::EBITS-1:0];
                if (n_ec == r_ecount) begin
                    n_vc = '0; n_st = S_SWAIT;
                end else begin
                    n_st = S_ERD;
                end
            end
            S_SWAIT: begin
                // let the last relaxation write land, then read entry 0
                n_st = S_SCAN;
            end
            S_DONE: begin
                n_ovalid = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_vc <= '0; r_ecount <= '0; r_last_walk <= 1'b0;
            r_ovalid <= 1'b0; r_found <= 1'b0;
        end else begin
            r_st <= n_st; r_vc <= n_vc; r_ecount <= n_ecount;
            r_last_walk <= n_last_walk; r_found <= n_found;
            // reset sweep raises no result
            r_ovalid <= (r_st == S_CLR && !r_res_pending) ? 1'b0 : n_ovalid;
        end
        r_ec <= n_ec; r_walk <= n_walk; r_stop <= n_stop; r_a <= n_a; r_b <= n_b;
        r_best <= n_best; r_bdist <= n_bdist; r_qv <= n_qv; r_e <= n_e;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pending <= 1'b0;
        end else if (in_fire && s_axis_tuser == dsp_pkg::REQ_CLEAR) begin
            r_res_pending <= 1'b1;
        end else if (r_st == S_CLR && n_st == S_IDLE) begin
            r_res_pending <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= dsp_pkg::NE) else $error("edge count overflow");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: bench/dijkstra_shortest_path_engine_top_test.sv
// Self-checking bench for the shortest path engine: a directed table, then
// random graph building, searches and queries, checked against a local model.
// Depends on dsp_pkg and the dijkstra_shortest_path_engine_top RTL.
`timescale 1ns / 1ps
module dijkstra_shortest_path_engine_top_test;

    localparam logic [2:0] REQ_UNKNOWN = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_TOP = 3'd7;
    localparam int NUM_RANDOM = 425;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    dijkstra_shortest_path_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // one request as the sender sees it
    typedef struct packed {
        logic [2:0]                req;
        logic [dsp_pkg::VBITS-1:0] va;
        logic [dsp_pkg::VBITS-1:0] vb;
        logic                      has_dest;
        logic [dsp_pkg::WBITS-1:0] dcost;
        logic                      can_drive;
        logic [dsp_pkg::WBITS-1:0] wcost;
        logic                      edge_excl;
        logic                      vert_excl;
        logic                      walk;
    } t_req;

    // graph and search state of the model
    int unsigned               n_edges;
    logic [dsp_pkg::VBITS-1:0] g_from  [dsp_pkg::NE];
    logic [dsp_pkg::VBITS-1:0] g_to    [dsp_pkg::NE];
    logic [dsp_pkg::WBITS-1:0] g_dw    [dsp_pkg::NE];
    logic [dsp_pkg::WBITS-1:0] g_ww    [dsp_pkg::NE];
    logic                      g_drive [dsp_pkg::NE];
    logic                      g_excl  [dsp_pkg::NE];
    logic                      v_avoid [dsp_pkg::NV];
    logic [dsp_pkg::DBITS-1:0] v_dist  [dsp_pkg::NV];
    logic                      v_seen  [dsp_pkg::NV];
    logic                      v_done  [dsp_pkg::NV];
    logic                      d_ok    [dsp_pkg::NV];
    logic [dsp_pkg::EBITS-1:0] d_pe    [dsp_pkg::NV];
    logic                      w_ok    [dsp_pkg::NV];
    logic [dsp_pkg::EBITS-1:0] w_pe    [dsp_pkg::NV];
    logic                      last_walk;

    dsp_pkg::t_res pending_results[$];
    int            mismatches = 0;
    logic          sender_busy = 1'b1;
    logic          hold_sink = 1'b0;
    logic          no_idle = 1'b0;

    function automatic void clear_graph();
        n_edges = 0;
        last_walk = 1'b0;
        for (int v = 0; v < dsp_pkg::NV; v++) begin
            v_avoid[v] = 1'b0; v_dist[v] = dsp_pkg::INF; v_seen[v] = 1'b0;
            v_done[v] = 1'b0;
            d_ok[v] = 1'b0; d_pe[v] = '0; w_ok[v] = 1'b0; w_pe[v] = '0;
        end
    endfunction

    function automatic void shortest_paths(int origin, logic walk, logic stop, int dest);
        int best;
        logic found;
        logic [dsp_pkg::DBITS:0] sum;
        for (int v = 0; v < dsp_pkg::NV; v++) begin
            v_dist[v] = dsp_pkg::INF; v_seen[v] = 1'b0; v_done[v] = 1'b0;
            if (walk) begin w_ok[v] = 1'b0; w_pe[v] = '0; end
            else begin d_ok[v] = 1'b0; d_pe[v] = '0; end
        end
        v_dist[origin] = '0;
        v_seen[origin] = 1'b1;
        forever begin
            best = 0; found = 1'b0;
            for (int v = 0; v < dsp_pkg::NV; v++)
                if (v_seen[v] && !v_done[v] && (!found || v_dist[v] < v_dist[best])) begin
                    best = v; found = 1'b1;
                end
            if (!found) return;
            v_done[best] = 1'b1;
            if (!walk && stop && best == dest) return;
            for (int e = 0; e < n_edges; e++) begin
                if (g_from[e] != best || g_excl[e] || v_avoid[g_to[e]]) continue;
                if (!walk && !g_drive[e]) continue;
                sum = v_dist[best] + (walk ? g_ww[e] : g_dw[e]);
                if (sum >= dsp_pkg::INF) sum = dsp_pkg::INF;
                if (v_dist[g_to[e]] > sum) begin
                    v_dist[g_to[e]] = sum[dsp_pkg::DBITS-1:0];
                    if (walk) begin w_ok[g_to[e]] = 1'b1; w_pe[g_to[e]] = 10'(e); end
                    else begin d_ok[g_to[e]] = 1'b1; d_pe[g_to[e]] = 10'(e); end
                    v_seen[g_to[e]] = 1'b1;
                end
            end
        end
    endfunction

    // apply one request to the model and return the result it produces
    function automatic dsp_pkg::t_res predict_response(t_req r);
        dsp_pkg::t_res res;
        logic ok;
        logic [dsp_pkg::EBITS-1:0] pe;
        res = '0;
        res.status = dsp_pkg::ST_OK;
        case (r.req)
            dsp_pkg::REQ_LOAD: begin
                if (n_edges >= dsp_pkg::NE) res.status = dsp_pkg::ST_FULL;
                else begin
                    g_from[n_edges] = r.va; g_to[n_edges] = r.vb;
                    g_dw[n_edges] = r.dcost; g_ww[n_edges] = r.wcost;
                    g_drive[n_edges] = r.can_drive; g_excl[n_edges] = r.edge_excl;
                    n_edges++;
                end
            end
            dsp_pkg::REQ_AVOID: v_avoid[r.va] = r.vert_excl;
            dsp_pkg::REQ_CLEAR: clear_graph();
            dsp_pkg::REQ_RUN: begin
                last_walk = r.walk;
                shortest_paths(r.va, r.walk, r.has_dest, r.vb);
            end
            dsp_pkg::REQ_QUERY: begin
                ok = last_walk ? w_ok[r.va] : d_ok[r.va];
                pe = last_walk ? w_pe[r.va] : d_pe[r.va];
                res.distance = v_dist[r.va];
                res.reachable = (v_dist[r.va] != dsp_pkg::INF);
                res.dok = d_ok[r.va];
                res.dpe = d_ok[r.va] ? d_pe[r.va] : '0;
                res.wok = w_ok[r.va];
                res.wpe = w_ok[r.va] ? w_pe[r.va] : '0;
                res.src = ok ? g_from[pe] : '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // drive one transfer, changing inputs at the falling edge; valid stays
    // high afterwards until the next idle cycle or pause drops it
    task automatic send_request(t_req r);
        while (!no_idle && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {3'b000, r.walk, r.vert_excl, r.edge_excl, r.wcost,
                          r.can_drive, r.dcost, r.has_dest, r.vb, r.va};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // model at acceptance, comparing when the result leaves
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(predict_response(t_req'({s_axis_tuser,
                s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[16],
                s_axis_tdata[32:17], s_axis_tdata[33], s_axis_tdata[49:34],
                s_axis_tdata[50], s_axis_tdata[51], s_axis_tdata[52]})));
    end

    always @(posedge i_clk) begin
        dsp_pkg::t_res got;
        dsp_pkg::t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[24], m_axis_tdata[25],
                   m_axis_tdata[35:26], m_axis_tdata[36], m_axis_tdata[46:37],
                   m_axis_tdata[54:47]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_axis_tdata[55] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
    end

    function automatic t_req load_edge(int a, int b, int dc, int wc, logic drv, logic ex);
        t_req r;
        r = '0;
        r.req = dsp_pkg::REQ_LOAD; r.va = 8'(a); r.vb = 8'(b);
        r.dcost = 16'(dc); r.wcost = 16'(wc);
        r.can_drive = drv; r.edge_excl = ex;
        return r;
    endfunction

    function automatic t_req make_req(logic [2:0] kind, int a, int b = 0,
                                      logic walk = 0, logic dest = 0, logic mark = 0);
        t_req r;
        r = '0;
        r.req = kind; r.va = 8'(a); r.vb = 8'(b); r.walk = walk; r.has_dest = dest;
        r.vert_excl = mark;
        return r;
    endfunction

    // random item over a small vertex window so searches find real paths
    function automatic t_req random_request();
        t_req r;
        logic [63:0] raw;
        int pick;
        int span;
        raw = {$urandom, $urandom};
        r = raw[$bits(t_req)-1:0];
        pick = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 255 : 15;
        r.va = 8'($urandom_range(span));
        r.vb = 8'($urandom_range(span));
        if (pick < 45) begin
            r.req = dsp_pkg::REQ_LOAD;
            if ($urandom_range(3) != 0) begin
                r.dcost = 16'($urandom_range(30));
                r.wcost = 16'($urandom_range(30));
            end
            r.edge_excl = ($urandom_range(9) == 0);
        end else if (pick < 52) r.req = dsp_pkg::REQ_AVOID;
        else if (pick < 54) r.req = dsp_pkg::REQ_CLEAR;
        else if (pick < 66) r.req = dsp_pkg::REQ_RUN;
        else if (pick < 97) r.req = dsp_pkg::REQ_QUERY;
        else r.req = 3'(REQ_UNKNOWN + $urandom_range(2));
        return r;
    endfunction

    typedef struct {
        t_req          r;
        logic          typed;
        dsp_pkg::t_res want;
    } t_row;

    t_row plan[$];

    initial begin
        t_row row;
        clear_graph();
        // directed table; typed rows are read off the behavior directly
        row.typed = 1'b1; row.want = '0;
        row.r = make_req(dsp_pkg::REQ_QUERY, 0);
        row.want.distance = dsp_pkg::INF; plan.push_back(row);
        row.want = '0;
        row.r = make_req(REQ_UNKNOWN, 3); plan.push_back(row);
        row.r = make_req(REQ_UNKNOWN_TOP, 255); plan.push_back(row);
        row.typed = 1'b0;
        plan.push_back('{load_edge(0, 1, 16'hffff, 0, 1, 0), 0, '0});
        plan.push_back('{load_edge(1, 255, 16'hffff, 16'hffff, 1, 0), 0, '0});
        plan.push_back('{load_edge(0, 2, 5, 7, 0, 0), 0, '0});
        plan.push_back('{load_edge(2, 3, 1, 1, 1, 1), 0, '0});
        plan.push_back('{load_edge(0, 3, 9, 2, 1, 0), 0, '0});
        plan.push_back('{load_edge(3, 255, 0, 0, 1, 0), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_AVOID, 2, 0, 0, 0, 1), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_RUN, 0, 255, 0, 1), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 255), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 3), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_RUN, 2, 0, 1), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 3), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_AVOID, 2, 0, 0, 0, 0), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_RUN, 0, 0, 1), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 255), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 2), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_RUN, 255, 7), 0, '0});
        plan.push_back('{make_req(dsp_pkg::REQ_QUERY, 255), 0, '0});
        row.typed = 1'b1; row.want = '0;
        row.r = make_req(dsp_pkg::REQ_CLEAR, 0); plan.push_back(row);
        row.r = make_req(dsp_pkg::REQ_QUERY, 255); row.want.distance = dsp_pkg::INF;
        plan.push_back(row);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            // queries and unknown requests leave the model untouched
            if (plan[i].typed && (plan[i].r.req == dsp_pkg::REQ_QUERY ||
                                  plan[i].r.req >= REQ_UNKNOWN)) begin
                if (predict_response(plan[i].r) !== plan[i].want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: expected %h", i, plan[i].want);
                end
            end
            send_request(plan[i].r);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 100) no_idle = 1'b1;
            if (n == 160) no_idle = 1'b0;
            if (n == 300) begin
                // pause until every outstanding result has come back
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
            send_request(random_request());
        end
        s_axis_tvalid <= 1'b0;
        sender_busy = 1'b0;
    end

    // long receiver hold while the sender keeps offering
    initial begin
        wait (i_rst_n);
        repeat (400) @(negedge i_clk);
        hold_sink = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        wait (i_rst_n && !sender_busy && pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
